// ===== rtl/hmf_pkg.sv =====
package hmf_pkg;

    localparam int MAX_RADIUS = 7;
    localparam int MAX_WIDTH  = 2048;
    localparam int RING_ROWS  = 2 * MAX_RADIUS + 1;
    localparam int RADIUS_W   = 3;
    localparam int WIDTH_W    = 12;
    localparam int HEIGHT_W   = 16;
    localparam int CFG_W      = 16;
    localparam int PIX_W      = 8;
    localparam int COL_W      = $clog2(MAX_WIDTH);
    localparam int RING_W     = $clog2(RING_ROWS);
    localparam int ADDR_W     = $clog2(RING_ROWS * MAX_WIDTH);
    localparam int WIN_W      = $clog2(2 * MAX_RADIUS + 1);
    localparam int CNT_W      = $clog2(RING_ROWS * RING_ROWS + 1);
    localparam int BIT_W      = $clog2(PIX_W);
    localparam int BURST_W    = $clog2(MAX_RADIUS + 2);

    localparam logic [1:0] REG_RADIUS = 2'd0;
    localparam logic [1:0] REG_WIDTH  = 2'd1;
    localparam logic [1:0] REG_HEIGHT = 2'd2;

    localparam logic KIND_PIXEL = 1'b0;
    localparam logic KIND_DRAIN = 1'b1;

    typedef struct packed {
        logic             kind;
        logic [PIX_W-1:0] pixel;
    } pix_t;

    typedef struct packed {
        logic [PIX_W-1:0] median;
        logic             end_of_burst;
        logic             end_of_frame;
    } res_t;

    typedef struct packed {
        logic write_pix;
        logic med_start;
        logic advance;
        logic load_out;
        logic eob;
    } cmd_t;

    typedef struct packed {
        logic ready;
        logic med_done;
    } stat_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_CHECK,
        ST_MED,
        ST_ADV,
        ST_DECIDE,
        ST_SEND
    } state_t;

endpackage

// ===== rtl/histogram_median_filter_8bit.sv =====
// Streaming 8-bit median filter over a (2*radius+1) square window with edge
// replication, pixels in raster order. A pixel request is stored in the line
// memory as it is accepted; each result then comes from the rank search: eight
// bit passes, each reading every window pixel once from the single-read line
// memory. A pixel request gives up to MAX_RADIUS+1 results, a drain request
// at most one; the next request is taken after the last result of the burst
// is delivered. No clearing pass.
module histogram_median_filter_8bit (
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic                      cfg_we,
    input  logic [1:0]                cfg_index,
    input  logic [hmf_pkg::CFG_W-1:0] cfg_data,
    input  logic                      pix_valid,
    output logic                      pix_stall,
    input  hmf_pkg::pix_t             pix_data,
    output logic                      res_valid,
    input  logic                      res_stall,
    output hmf_pkg::res_t             res_data
);
    import hmf_pkg::*;

    cmd_t  cmd;
    stat_t stat;

    hmf_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .pix_valid (pix_valid),
        .pix_kind  (pix_data.kind),
        .pix_stall (pix_stall),
        .res_valid (res_valid),
        .res_stall (res_stall),
        .stat      (stat),
        .cmd       (cmd)
    );

    hmf_datapath u_dp (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .pix_data  (pix_data),
        .cmd       (cmd),
        .stat      (stat),
        .res_data  (res_data)
    );

endmodule

// ===== rtl/hmf_ctrl.sv =====
module hmf_ctrl (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          pix_valid,
    input  logic          pix_kind,
    output logic          pix_stall,
    output logic          res_valid,
    input  logic          res_stall,
    input  hmf_pkg::stat_t stat,
    output hmf_pkg::cmd_t  cmd
);
    import hmf_pkg::*;

    state_t             state_reg, state_next;
    logic [BURST_W-1:0] n_reg, n_next;
    logic               kind_reg, kind_next;
    logic [BURST_W-1:0] cap;
    logic               more;

    assign cap  = (kind_reg == KIND_DRAIN) ? BURST_W'(1) : BURST_W'(MAX_RADIUS + 1);
    assign more = (n_reg < cap) && stat.ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            n_reg     <= '0;
            kind_reg  <= KIND_PIXEL;
        end
        else
        begin
            state_reg <= state_next;
            n_reg     <= n_next;
            kind_reg  <= kind_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        n_next     = n_reg;
        kind_next  = kind_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (pix_valid)
                begin
                    state_next = ST_CHECK;
                    n_next     = '0;
                    kind_next  = pix_kind;
                end
            end
            ST_CHECK:  state_next = more ? ST_MED : ST_IDLE;
            ST_MED:    if (stat.med_done) state_next = ST_ADV;
            ST_ADV:
            begin
                state_next = ST_DECIDE;
                n_next     = n_reg + BURST_W'(1);
            end
            ST_DECIDE: state_next = ST_SEND;
            ST_SEND:
            begin
                if (!res_stall)
                    state_next = more ? ST_MED : ST_IDLE;
            end
            default:   state_next = ST_IDLE;
        endcase
    end

    always_comb
    begin
        cmd       = '0;
        pix_stall = (state_reg != ST_IDLE);
        res_valid = (state_reg == ST_SEND);
        unique case (state_reg)
            ST_IDLE:   cmd.write_pix = pix_valid && (pix_kind == KIND_PIXEL);
            ST_CHECK:  cmd.med_start = more;
            ST_MED:    cmd = '0;
            ST_ADV:    cmd.advance = 1'b1;
            ST_DECIDE:
            begin
                cmd.load_out = 1'b1;
                cmd.eob      = !more;
            end
            ST_SEND:   cmd.med_start = !res_stall && more;
            default:   cmd = '0;
        endcase
    end

    a_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
        (pix_valid && !pix_stall) |=> (state_reg == ST_CHECK))
        else $error("accepted request did not start a burst");

    a_burst_cap: assert property (@(posedge clk) disable iff (!rst_n)
        n_reg <= BURST_W'(MAX_RADIUS + 1))
        else $error("burst count beyond cap");

    a_send_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_SEND && res_stall) |=> (state_reg == ST_SEND))
        else $error("result dropped while stalled");

endmodule

// ===== rtl/hmf_datapath.sv =====
module hmf_datapath (
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       cfg_we,
    input  logic [1:0]                 cfg_index,
    input  logic [hmf_pkg::CFG_W-1:0]  cfg_data,
    input  hmf_pkg::pix_t              pix_data,
    input  hmf_pkg::cmd_t              cmd,
    output hmf_pkg::stat_t             stat,
    output hmf_pkg::res_t              res_data
);
    import hmf_pkg::*;

    logic [RADIUS_W-1:0] radius_reg;
    logic [WIDTH_W-1:0]  width_reg;
    logic [HEIGHT_W-1:0] height_reg;

    logic [RADIUS_W-1:0] r_eff;
    logic [WIDTH_W-1:0]  w_eff, w_m1;
    logic [HEIGHT_W-1:0] h_eff, h_m1;
    logic                cfg_hit;

    logic [COL_W-1:0]    rec_col_reg, out_x_reg;
    logic [HEIGHT_W-1:0] rec_row_reg, out_y_reg;
    logic [RING_W-1:0]   rec_ring_reg, out_ring_reg;

    logic                full;
    logic [COL_W-1:0]    wcol;
    logic [HEIGHT_W-1:0] wrow;
    logic [RING_W-1:0]   wring;
    logic [ADDR_W-1:0]   wr_addr, rd_addr;

    logic [PIX_W-1:0]    mem [RING_ROWS * MAX_WIDTH];
    logic [PIX_W-1:0]    rd_data_reg;

    logic [HEIGHT_W:0]   ly;
    logic [WIDTH_W:0]    lx;

    logic [BIT_W-1:0]    bit_reg;
    logic [WIN_W-1:0]    dy_reg, dx_reg;
    logic                issuing_reg, rv_reg, rl_reg, done_reg;
    logic [PIX_W-1:0]    prefix_reg, prefix_next, median_reg, mask;
    logic [CNT_W-1:0]    k_reg, cnt_reg, cnt_sum, rank;
    logic [WIN_W-1:0]    span;
    logic                match, eof_reg;

    logic signed [HEIGHT_W+2:0] yy, ydelta;
    logic signed [WIDTH_W+2:0]  xx;
    logic [HEIGHT_W-1:0]        rrow;
    logic [COL_W-1:0]           rcol;
    logic signed [RING_W+1:0]   ring_s;
    logic [RING_W-1:0]          rring;

    assign r_eff = (radius_reg == '0) ? RADIUS_W'(1) :
                   (radius_reg > RADIUS_W'(MAX_RADIUS)) ? RADIUS_W'(MAX_RADIUS) : radius_reg;
    assign w_eff = (width_reg == '0) ? WIDTH_W'(1) :
                   (width_reg > WIDTH_W'(MAX_WIDTH)) ? WIDTH_W'(MAX_WIDTH) : width_reg;
    assign h_eff = (height_reg == '0) ? HEIGHT_W'(1) : height_reg;
    assign w_m1  = w_eff - WIDTH_W'(1);
    assign h_m1  = h_eff - HEIGHT_W'(1);
    assign span  = WIN_W'({r_eff, 1'b0});
    assign rank  = CNT_W'(2 * r_eff * (r_eff + 1));
    assign cfg_hit = cfg_we && (cfg_index == REG_RADIUS || cfg_index == REG_WIDTH ||
                                cfg_index == REG_HEIGHT);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            radius_reg <= RADIUS_W'(1);
            width_reg  <= WIDTH_W'(MAX_WIDTH);
            height_reg <= HEIGHT_W'(1);
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                REG_RADIUS: radius_reg <= cfg_data[RADIUS_W-1:0];
                REG_WIDTH:  width_reg  <= cfg_data[WIDTH_W-1:0];
                REG_HEIGHT: height_reg <= cfg_data[HEIGHT_W-1:0];
                default:    radius_reg <= radius_reg;
            endcase
        end
    end

    assign full  = (rec_row_reg == h_eff);
    assign wcol  = full ? '0 : rec_col_reg;
    assign wrow  = full ? '0 : rec_row_reg;
    assign wring = full ? '0 : rec_ring_reg;
    assign wr_addr = ADDR_W'(wring * MAX_WIDTH) + ADDR_W'(wcol);

    assign ly = ({1'b0, out_y_reg} + (HEIGHT_W+1)'(r_eff) > {1'b0, h_m1}) ?
                {1'b0, h_m1} : {1'b0, out_y_reg} + (HEIGHT_W+1)'(r_eff);
    assign lx = ((WIDTH_W+1)'(out_x_reg) + (WIDTH_W+1)'(r_eff) > {1'b0, w_m1}) ?
                {1'b0, w_m1} : (WIDTH_W+1)'(out_x_reg) + (WIDTH_W+1)'(r_eff);
    assign stat.ready = (out_y_reg != h_eff) &&
                        (({1'b0, rec_row_reg} > ly) ||
                         (({1'b0, rec_row_reg} == ly) &&
                          ((WIDTH_W+1)'(rec_col_reg) > lx)));
    assign stat.med_done = done_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rec_col_reg  <= '0;
            rec_row_reg  <= '0;
            rec_ring_reg <= '0;
            out_x_reg    <= '0;
            out_y_reg    <= '0;
            out_ring_reg <= '0;
        end
        else if (cfg_hit)
        begin
            rec_col_reg  <= '0;
            rec_row_reg  <= '0;
            rec_ring_reg <= '0;
            out_x_reg    <= '0;
            out_y_reg    <= '0;
            out_ring_reg <= '0;
        end
        else
        begin
            if (cmd.write_pix)
            begin
                if (full)
                begin
                    out_x_reg    <= '0;
                    out_y_reg    <= '0;
                    out_ring_reg <= '0;
                end
                if ({1'b0, wcol} == w_m1)
                begin
                    rec_col_reg  <= '0;
                    rec_row_reg  <= wrow + HEIGHT_W'(1);
                    rec_ring_reg <= (wring == RING_W'(RING_ROWS - 1)) ? '0 :
                                    wring + RING_W'(1);
                end
                else
                begin
                    rec_col_reg  <= wcol + COL_W'(1);
                    rec_row_reg  <= wrow;
                    rec_ring_reg <= wring;
                end
            end
            if (cmd.advance)
            begin
                if ({1'b0, out_x_reg} == w_m1)
                begin
                    out_x_reg    <= '0;
                    out_y_reg    <= out_y_reg + HEIGHT_W'(1);
                    out_ring_reg <= (out_ring_reg == RING_W'(RING_ROWS - 1)) ? '0 :
                                    out_ring_reg + RING_W'(1);
                end
                else
                begin
                    out_x_reg <= out_x_reg + COL_W'(1);
                end
            end
        end
    end

    always_comb
    begin
        yy = $signed({3'b000, out_y_reg}) + $signed({{(HEIGHT_W-WIN_W+3){1'b0}}, dy_reg})
             - $signed({{(HEIGHT_W+3-RADIUS_W){1'b0}}, r_eff});
        if (yy < 0)
            rrow = '0;
        else if (yy > $signed({3'b000, h_m1}))
            rrow = h_m1;
        else
            rrow = yy[HEIGHT_W-1:0];
        ydelta = $signed({3'b000, rrow}) - $signed({3'b000, out_y_reg});
        ring_s = $signed({2'b00, out_ring_reg}) + ydelta[RING_W+1:0];
        if (ring_s < 0)
            ring_s = ring_s + (RING_W+2)'(RING_ROWS);
        else if (ring_s >= $signed((RING_W+2)'(RING_ROWS)))
            ring_s = ring_s - (RING_W+2)'(RING_ROWS);
        rring = ring_s[RING_W-1:0];
        xx = $signed({3'b000, (WIDTH_W)'(out_x_reg)})
             + $signed({{(WIDTH_W-WIN_W+3){1'b0}}, dx_reg})
             - $signed({{(WIDTH_W+3-RADIUS_W){1'b0}}, r_eff});
        if (xx < 0)
            rcol = '0;
        else if (xx > $signed({3'b000, w_m1}))
            rcol = w_m1[COL_W-1:0];
        else
            rcol = xx[COL_W-1:0];
    end

    assign rd_addr = ADDR_W'(rring * MAX_WIDTH) + ADDR_W'(rcol);

    always_ff @(posedge clk)
    begin
        if (cmd.write_pix)
            mem[wr_addr] <= pix_data.pixel;
        rd_data_reg <= mem[rd_addr];
    end

    assign mask    = PIX_W'(8'hFF << bit_reg);
    assign match   = ((rd_data_reg & mask) == (prefix_reg & mask));
    assign cnt_sum = cnt_reg + CNT_W'(match);

    always_comb
    begin
        prefix_next = prefix_reg;
        if (cnt_sum <= k_reg)
            prefix_next[bit_reg] = 1'b1;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            issuing_reg <= 1'b0;
            rv_reg      <= 1'b0;
            rl_reg      <= 1'b0;
            done_reg    <= 1'b0;
        end
        else
        begin
            done_reg <= 1'b0;
            rv_reg   <= issuing_reg;
            rl_reg   <= issuing_reg && (dy_reg == span) && (dx_reg == span);
            if (cmd.med_start)
                issuing_reg <= 1'b1;
            else if (issuing_reg && (dy_reg == span) && (dx_reg == span))
                issuing_reg <= 1'b0;
            else if (rv_reg && rl_reg && (bit_reg != '0))
                issuing_reg <= 1'b1;
            if (rv_reg && rl_reg && (bit_reg == '0))
                done_reg <= 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.med_start)
        begin
            bit_reg    <= BIT_W'(PIX_W - 1);
            dy_reg     <= '0;
            dx_reg     <= '0;
            prefix_reg <= '0;
            k_reg      <= rank;
            cnt_reg    <= '0;
        end
        else
        begin
            if (issuing_reg)
            begin
                if (dx_reg == span)
                begin
                    dx_reg <= '0;
                    dy_reg <= (dy_reg == span) ? '0 : dy_reg + WIN_W'(1);
                end
                else
                begin
                    dx_reg <= dx_reg + WIN_W'(1);
                end
            end
            if (rv_reg)
            begin
                if (rl_reg)
                begin
                    cnt_reg    <= '0;
                    prefix_reg <= prefix_next;
                    if (cnt_sum <= k_reg)
                        k_reg <= k_reg - cnt_sum;
                    if (bit_reg == '0)
                        median_reg <= prefix_next;
                    else
                        bit_reg <= bit_reg - BIT_W'(1);
                end
                else
                begin
                    cnt_reg <= cnt_sum;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.advance)
            eof_reg <= (out_y_reg == h_m1) && ({1'b0, out_x_reg} == w_m1);
        if (cmd.load_out)
        begin
            res_data.median       <= median_reg;
            res_data.end_of_burst <= cmd.eob;
            res_data.end_of_frame <= eof_reg;
        end
    end

endmodule

// ===== bench/histogram_median_filter_8bit_tb.sv =====
`timescale 1ns / 100ps

module histogram_median_filter_8bit_tb;
    import hmf_pkg::*;

    localparam int LIMIT = 6000000;
    localparam int HOLD_CYCLES = 3000;
    localparam int SETTLE = 2000;

    typedef struct {
        bit         is_cfg;
        logic [1:0] idx;
        logic [15:0] val;
        pix_t       req;
        bit         typed;
        res_t       want;
    } dir_row_t;

    logic clk;
    logic rst_n;
    logic cfg_we;
    logic [1:0] cfg_index;
    logic [CFG_W-1:0] cfg_data;
    logic pix_valid;
    logic pix_stall;
    pix_t pix_data;
    logic res_valid;
    logic res_stall;
    res_t res_data;

    histogram_median_filter_8bit u_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .pix_valid (pix_valid),
        .pix_stall (pix_stall),
        .pix_data  (pix_data),
        .res_valid (res_valid),
        .res_stall (res_stall),
        .res_data  (res_data)
    );

    // filter model state
    logic [7:0] ring_pix [RING_ROWS*MAX_WIDTH];
    longint unsigned px_rcv;
    longint unsigned px_out;
    logic [2:0]  m_rad;
    logic [11:0] m_wid;
    logic [15:0] m_hgt;

    res_t medians_q [$];
    res_t fresh_q [$];
    dir_row_t dir_rows [$];
    int errors;
    int cycles;
    int max_gap;
    bit hold_req;
    int pix_sent;

    initial clk = 1'b0;

    always
    begin
        #4 clk = 1'b1;
        #4 clk = 1'b0;
    end

    function automatic int eff_r();
        if (m_rad < 1) return 1;
        if (m_rad > MAX_RADIUS) return MAX_RADIUS;
        return m_rad;
    endfunction

    function automatic int eff_w();
        if (m_wid < 1) return 1;
        if (m_wid > MAX_WIDTH) return MAX_WIDTH;
        return m_wid;
    endfunction

    function automatic int eff_h();
        return (m_hgt < 1) ? 1 : m_hgt;
    endfunction

    function automatic bit median_ready();
        longint unsigned w;
        longint unsigned h;
        longint unsigned r;
        longint unsigned y;
        longint unsigned x;
        longint unsigned ly;
        longint unsigned lx;
        w = eff_w();
        h = eff_h();
        r = eff_r();
        if (px_out >= w * h) return 0;
        y = px_out / w;
        x = px_out % w;
        ly = (y + r > h - 1) ? h - 1 : y + r;
        lx = (x + r > w - 1) ? w - 1 : x + r;
        return px_rcv > ly * w + lx;
    endfunction

    function automatic logic [7:0] window_median();
        int hist [256];
        int w;
        int h;
        int r;
        int y;
        int x;
        int row;
        int col;
        int rank;
        int sum;
        int v;
        w = eff_w();
        h = eff_h();
        r = eff_r();
        y = px_out / w;
        x = px_out % w;
        for (int i = 0; i < 256; i++) hist[i] = 0;
        for (int dy = -r; dy <= r; dy++)
        begin
            row = y + dy;
            if (row < 0) row = 0;
            if (row > h - 1) row = h - 1;
            for (int dx = -r; dx <= r; dx++)
            begin
                col = x + dx;
                if (col < 0) col = 0;
                if (col > w - 1) col = w - 1;
                hist[ring_pix[(row % RING_ROWS) * MAX_WIDTH + col]]++;
            end
        end
        rank = 2 * r * r + 2 * r;
        sum = 0;
        for (v = 0; v < 255; v++)
        begin
            sum += hist[v];
            if (sum > rank) break;
        end
        return v[7:0];
    endfunction

    // fills fresh_q with the medians one request releases
    function automatic void filter_request(pix_t p);
        longint unsigned total;
        int cap;
        res_t rs;
        total = longint'(eff_w()) * eff_h();
        fresh_q.delete();
        if (p.kind == KIND_PIXEL)
        begin
            if (px_rcv >= total)
            begin
                px_rcv = 0;
                px_out = 0;
            end
            ring_pix[((px_rcv / eff_w()) % RING_ROWS) * MAX_WIDTH + (px_rcv % eff_w())] = p.pixel;
            px_rcv++;
            cap = MAX_RADIUS + 1;
        end
        else
            cap = 1;
        while (fresh_q.size() < cap && median_ready())
        begin
            rs.median = window_median();
            rs.end_of_burst = 1'b0;
            rs.end_of_frame = (px_out + 1 == total);
            fresh_q.push_back(rs);
            px_out++;
        end
        if (fresh_q.size() > 0) fresh_q[fresh_q.size()-1].end_of_burst = 1'b1;
    endfunction

    task automatic wait_idle();
        while (medians_q.size() != 0) @(posedge clk);
        repeat (64) @(posedge clk);
    endtask

    task automatic write_reg(logic [1:0] idx, logic [15:0] val);
        @(negedge clk);
        pix_valid <= 1'b0;
        wait_idle();
        @(negedge clk);
        cfg_we <= 1'b1;
        cfg_index <= idx;
        cfg_data <= val;
        case (idx)
            REG_RADIUS: m_rad = val[2:0];
            REG_WIDTH:  m_wid = val[11:0];
            REG_HEIGHT: m_hgt = val[15:0];
            default: ;
        endcase
        px_rcv = 0;
        px_out = 0;
        @(negedge clk);
        cfg_we <= 1'b0;
    endtask

    task automatic send_req(pix_t p, bit typed, res_t want);
        int gap;
        gap = max_gap ? $urandom_range(0, max_gap) : 0;
        if (gap > 0)
        begin
            @(negedge clk);
            pix_valid <= 1'b0;
            repeat (gap - 1) @(negedge clk);
        end
        @(negedge clk);
        pix_valid <= 1'b1;
        pix_data <= p;
        do @(posedge clk); while (pix_stall);
        filter_request(p);
        pix_sent++;
        if (typed)
            medians_q.push_back(want);
        else
            foreach (fresh_q[i]) medians_q.push_back(fresh_q[i]);
    endtask

    task automatic send_pixel(logic [7:0] v);
        pix_t p;
        res_t none;
        p.kind = KIND_PIXEL;
        p.pixel = v;
        none = '0;
        send_req(p, 0, none);
    endtask

    task automatic send_drain();
        pix_t p;
        res_t none;
        p.kind = KIND_DRAIN;
        p.pixel = $urandom_range(0, 255);
        none = '0;
        send_req(p, 0, none);
    endtask

    task automatic drain_all();
        while (median_ready()) send_drain();
        send_drain();
    endtask

    task automatic push_cfg(logic [1:0] idx, logic [15:0] val);
        dir_row_t d;
        d = '{default: '0};
        d.is_cfg = 1;
        d.idx = idx;
        d.val = val;
        dir_rows.push_back(d);
    endtask

    task automatic push_req(logic kind, logic [7:0] v, bit typed, res_t want);
        dir_row_t d;
        d = '{default: '0};
        d.req.kind = kind;
        d.req.pixel = v;
        d.typed = typed;
        d.want = want;
        dir_rows.push_back(d);
    endtask

    function automatic logic [7:0] rand_pixel();
        if ($urandom_range(0, 3) == 0) return 8'($urandom_range(0, 3) * 85);
        return 8'($urandom_range(0, 255));
    endfunction

    task automatic run_frame(int n);
        for (int i = 0; i < n; i++)
        begin
            if ($urandom_range(0, 7) == 0) send_drain();
            send_pixel(rand_pixel());
        end
    endtask

    task automatic run_phase(int r, int w, int h, int n);
        write_reg(REG_RADIUS, 16'(r));
        write_reg(REG_WIDTH, 16'(w));
        write_reg(REG_HEIGHT, 16'(h));
        run_frame(n);
        drain_all();
    endtask

    always @(posedge clk)
    begin
        if (res_valid && !res_stall)
        begin
            if (medians_q.size() == 0)
            begin
                errors++;
                if (errors <= 10)
                    $display("unexpected result %h/%0d/%0d", res_data.median,
                             res_data.end_of_burst, res_data.end_of_frame);
            end
            else
            begin
                if (res_data.median !== medians_q[0].median ||
                    res_data.end_of_burst !== medians_q[0].end_of_burst ||
                    res_data.end_of_frame !== medians_q[0].end_of_frame)
                begin
                    errors++;
                    if (errors <= 10)
                        $display("mismatch: exp %h/%0d/%0d got %h/%0d/%0d",
                                 medians_q[0].median, medians_q[0].end_of_burst,
                                 medians_q[0].end_of_frame, res_data.median,
                                 res_data.end_of_burst, res_data.end_of_frame);
                end
                void'(medians_q.pop_front());
            end
        end
    end

    always @(posedge clk)
    begin
        cycles++;
        if (cycles == LIMIT)
        begin
            $display("Mismatches found");
            $finish;
        end
    end

    // result side back-pressure
    initial begin
        int n;
        res_stall = 1'b0;
        @(posedge rst_n);
        forever
        begin
            if (hold_req)
            begin
                hold_req = 0;
                n = HOLD_CYCLES;
            end
            else
                n = max_gap ? $urandom_range(0, max_gap) : 0;
            if (n > 0)
            begin
                @(negedge clk);
                res_stall <= 1'b1;
                repeat (n - 1) @(negedge clk);
            end
            @(negedge clk);
            res_stall <= 1'b0;
            do @(posedge clk); while (!(res_valid && !res_stall));
        end
    end

    initial begin
        int r;
        int w;
        int h;
        res_t t;
        rst_n = 1'b0;
        cfg_we = 1'b0;
        cfg_index = '0;
        cfg_data = '0;
        pix_valid = 1'b0;
        pix_data = '0;
        errors = 0;
        cycles = 0;
        max_gap = 15;
        hold_req = 0;
        pix_sent = 0;
        px_rcv = 0;
        px_out = 0;
        m_rad = 3'd1;
        m_wid = 12'd2048;
        m_hgt = 16'd1;
        repeat (3) @(negedge clk);
        rst_n = 1'b1;

        // single pixel frames: median is the pixel itself
        push_cfg(REG_WIDTH, 16'd1);
        push_cfg(REG_HEIGHT, 16'd1);
        t = '{median: 8'hAB, end_of_burst: 1'b1, end_of_frame: 1'b1};
        push_req(KIND_PIXEL, 8'hAB, 1, t);
        t.median = 8'h00;
        push_req(KIND_PIXEL, 8'h00, 1, t);
        t.median = 8'hFF;
        push_req(KIND_PIXEL, 8'hFF, 1, t);
        push_req(KIND_DRAIN, 8'hFF, 0, t);
        push_cfg(REG_RADIUS, 16'd0);
        push_cfg(REG_WIDTH, 16'd3);
        push_cfg(REG_HEIGHT, 16'd2);
        push_req(KIND_PIXEL, 8'h10, 0, t);
        push_req(KIND_PIXEL, 8'hF0, 0, t);
        push_req(KIND_PIXEL, 8'h33, 0, t);
        push_req(KIND_PIXEL, 8'h80, 0, t);
        push_req(KIND_PIXEL, 8'h07, 0, t);
        push_req(KIND_PIXEL, 8'hC5, 0, t);
        push_req(KIND_DRAIN, 8'h00, 0, t);
        push_req(KIND_DRAIN, 8'h00, 0, t);
        push_cfg(REG_RADIUS, 16'd7);
        push_req(KIND_PIXEL, 8'h01, 0, t);
        push_req(KIND_PIXEL, 8'hFE, 0, t);
        push_req(KIND_PIXEL, 8'h55, 0, t);
        push_req(KIND_PIXEL, 8'hAA, 0, t);
        push_req(KIND_PIXEL, 8'h00, 0, t);
        push_req(KIND_PIXEL, 8'hFF, 0, t);

        foreach (dir_rows[i])
        begin
            if (dir_rows[i].is_cfg)
                write_reg(dir_rows[i].idx, dir_rows[i].val);
            else
                send_req(dir_rows[i].req, dir_rows[i].typed, dir_rows[i].want);
        end
        drain_all();

        // register extremes
        run_phase(1, 4095, 0, 24);
        run_phase(2, 0, 65535, 20);
        run_phase(7, 5, 3, 15);
        run_phase(1, 2048, 1, 12);

        // long receiver hold-off while requests keep coming
        write_reg(REG_RADIUS, 16'd1);
        write_reg(REG_WIDTH, 16'd8);
        write_reg(REG_HEIGHT, 16'd4);
        hold_req = 1;
        max_gap = 0;
        run_frame(32);
        drain_all();
        wait_idle();
        max_gap = 15;

        while (pix_sent < 480)
        begin
            max_gap = ($urandom_range(0, 3) == 0) ? 0 : 15;
            r = $urandom_range(0, 3);
            if ($urandom_range(0, 9) == 0) r = $urandom_range(4, 7);
            if (r >= 4)
            begin
                w = $urandom_range(1, 6);
                h = $urandom_range(1, 4);
            end
            else
            begin
                w = $urandom_range(1, 12);
                h = $urandom_range(1, 8);
            end
            write_reg(REG_RADIUS, 16'(r));
            write_reg(REG_WIDTH, 16'(w));
            write_reg(REG_HEIGHT, 16'(h));
            if ($urandom_range(0, 9) == 0)
                run_frame($urandom_range(1, w * h));
            else
                run_frame(w * h);
            if ($urandom_range(0, 2) == 0)
            begin
                if ($urandom_range(0, 1) == 0) drain_all();
                run_frame(w * h);
            end
            drain_all();
        end

        @(negedge clk);
        pix_valid <= 1'b0;
        while (medians_q.size() != 0) @(posedge clk);
        repeat (SETTLE) @(posedge clk);
        if (errors == 0 && medians_q.size() == 0)
            $display("No mismatches found");
        else
            $display("Mismatches found");
        $finish;
    end

endmodule

// ===== files.f =====
rtl/hmf_pkg.sv
rtl/hmf_ctrl.sv
rtl/hmf_datapath.sv
rtl/histogram_median_filter_8bit.sv
bench/histogram_median_filter_8bit_tb.sv
